// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: screen geometry,
// operation codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // field and address widths
  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OP_W   = 3;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  // operation codes, the remaining codes are no-ops
  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_REPOS   = 3'd2,
    OP_FILL    = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_done;
    logic op_put;
    logic slot_free;
  } tcw_sts_t;

endpackage

// ===== design/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences the post-reset clearing pass, executes one word,
// waits for store walks (scroll, fill) and hands the result to the output.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tcw_sts_t sts_i,
  output tcw_cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.walk_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_walk ? ST_WALK : ST_RESP;
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          // a put resumes with its write once the scroll is done
          state_d = sts_i.op_put ? ST_EXEC : ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          in_stall_o     = 1'b0;
          if (in_valid_i) begin
            cmd_o.load_item = 1'b1;
            state_d         = ST_EXEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath: cell store, cursor, word registers, the store walker used for
// clearing, scrolling and filling, and the output register.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcw_cmd_t          cmd_i,
  output tcw_sts_t          sts_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        attribute_i,
  input  logic [4:0]        line_count_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [ADDR_W-1:0] cell_index_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [CELL_W-1:0] cell_value_o
);

  localparam logic [ADDR_W-1:0] LastCell = ADDR_W'(CELLS - 1);

  // word registers
  logic [OP_W-1:0]   op_q;
  logic [7:0]        char_q, attr_q;
  logic [4:0]        lines_q;
  logic [COL_W-1:0]  col_in_q;
  logic [ROW_W-1:0]  row_in_q;
  logic [ADDR_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= operation_i;
      char_q   <= char_code_i;
      attr_q   <= attribute_i;
      lines_q  <= line_count_i;
      col_in_q <= column_i;
      row_in_q <= row_i;
      idx_q    <= cell_index_i;
    end
  end

  // cursor and walker registers
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              walk_run_q, walk_run_d;
  logic [ADDR_W-1:0] scan_q, scan_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic              copy_en_q, copy_en_d;
  logic [CELL_W-1:0] fill_val_q, fill_val_d;
  logic              wp_valid_q, wp_valid_d;
  logic [ADDR_W-1:0] wp_addr_q, wp_addr_d;
  logic              wp_copy_q, wp_copy_d;

  // cell store ports
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] cell_mem [CELLS];
  logic [CELL_W-1:0] rdata_q;

  // operand decode
  logic [4:0]        lines_sat;
  logic [5:0]        row_sum;
  logic [ADDR_W-1:0] cur_addr;
  logic [CELL_W-1:0] new_cell;
  logic [ADDR_W:0]   src_addr;
  logic              src_ok;
  logic              idx_ok;

  assign lines_sat = (lines_q > 5'(ROWS)) ? 5'(ROWS) : lines_q;
  assign row_sum   = {1'b0, row_q} + {1'b0, lines_sat};
  assign cur_addr  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign new_cell  = {attr_q, char_q};
  assign src_addr  = {1'b0, scan_q} + {1'b0, off_q};
  assign src_ok    = copy_en_q && (src_addr < (ADDR_W + 1)'(CELLS));
  assign idx_ok    = idx_q < ADDR_W'(CELLS);

  // walk needed by the current word
  always_comb begin
    sts_o.need_walk = 1'b0;
    case (op_q)
      OP_PUT:     sts_o.need_walk = (row_q == ROW_W'(ROWS));
      OP_NEWLINE: sts_o.need_walk = (lines_sat != '0) && (row_sum >= 6'(ROWS));
      OP_FILL:    sts_o.need_walk = 1'b1;
      default:    sts_o.need_walk = 1'b0;
    endcase
  end

  assign sts_o.walk_done = wp_valid_q && (wp_addr_q == LastCell);
  assign sts_o.op_put    = (op_q == OP_PUT);
  assign sts_o.slot_free = !out_valid_o || !out_stall_i;

  // execution and walker next state
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    walk_run_d = walk_run_q;
    scan_d     = scan_q;
    off_d      = off_q;
    copy_en_d  = copy_en_q;
    fill_val_d = fill_val_q;
    wp_valid_d = 1'b0;
    wp_addr_d  = wp_addr_q;
    wp_copy_d  = wp_copy_q;
    mem_we     = 1'b0;
    mem_waddr  = wp_addr_q;
    mem_wdata  = wp_copy_q ? rdata_q : fill_val_q;
    mem_re     = 1'b0;
    mem_raddr  = src_addr[ADDR_W-1:0];

    // walker: read the source ahead, write the destination behind from the registered read data
    if (walk_run_q) begin
      mem_re     = src_ok;
      wp_valid_d = 1'b1;
      wp_addr_d  = scan_q;
      wp_copy_d  = src_ok;
      scan_d     = scan_q + 1'b1;
      if (scan_q == LastCell) begin
        walk_run_d = 1'b0;
      end
    end
    if (wp_valid_q) begin
      mem_we = 1'b1;
    end

    // one word
    if (cmd_i.exec) begin
      case (op_q)
        OP_PUT: begin
          if (row_q == ROW_W'(ROWS)) begin
            // cursor past the end: scroll one line, back up one row
            row_d      = ROW_W'(ROWS - 1);
            walk_run_d = 1'b1;
            scan_d     = '0;
            off_d      = ADDR_W'(COLUMNS);
            copy_en_d  = 1'b1;
            fill_val_d = BLANK_CELL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = new_cell;
            if (col_q == COL_W'(COLUMNS - 1)) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
        end
        OP_NEWLINE: begin
          if (lines_sat != '0) begin
            col_d = '0;
            if (row_sum >= 6'(ROWS)) begin
              walk_run_d = 1'b1;
              scan_d     = '0;
              off_d      = ADDR_W'(lines_sat) * ADDR_W'(COLUMNS);
              copy_en_d  = 1'b1;
              fill_val_d = BLANK_CELL;
            end else begin
              row_d = row_sum[ROW_W-1:0];
            end
          end
        end
        OP_REPOS: begin
          col_d = (col_in_q > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : col_in_q;
          row_d = (row_in_q > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : row_in_q;
        end
        OP_FILL: begin
          col_d      = '0;
          row_d      = '0;
          walk_run_d = 1'b1;
          scan_d     = '0;
          copy_en_d  = 1'b0;
          fill_val_d = new_cell;
        end
        OP_READ: begin
          mem_re    = idx_ok;
          mem_raddr = idx_q;
        end
        default: begin
        end
      endcase
    end
  end

  // cursor and walker state, the walker starts the clearing pass at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      walk_run_q <= 1'b1;
      scan_q     <= '0;
      off_q      <= '0;
      copy_en_q  <= 1'b0;
      fill_val_q <= BLANK_CELL;
      wp_valid_q <= 1'b0;
      wp_addr_q  <= '0;
      wp_copy_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      walk_run_q <= walk_run_d;
      scan_q     <= scan_d;
      off_q      <= off_d;
      copy_en_q  <= copy_en_d;
      fill_val_q <= fill_val_d;
      wp_valid_q <= wp_valid_d;
      wp_addr_q  <= wp_addr_d;
      wp_copy_q  <= wp_copy_d;
    end
  end

  // cell store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= cell_mem[mem_raddr];
    end
  end

  // output register
  logic              out_valid_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [CELL_W-1:0] out_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_col_q  <= col_q;
      out_row_q  <= row_q;
      out_cell_q <= ((op_q == OP_READ) && idx_ok) ? rdata_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign cell_value_o = out_cell_q;

endmodule

// ===== design/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console over an 80x25 store of 16-bit cells (attribute high,
// character low) with a linear cursor: put, newline, reposition, fill, read.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    operation .. cell_index
//  out      output     out_valid_o / out_stall_i  cursor_col, cursor_row,
//                                                 cell_value
//
//  put, newline without scroll, reposition, read: no store walk.
//  newline with scroll, fill and put with scroll walk the whole store,
//  one cell per cycle over the single-write-port cell store.
//  after reset the store is blanked in a clearing pass, in_stall_o
//  stays high meanwhile.
//  a result waiting in the output register does not hold off the next word,
//  but that word's result waits for the slot and in_stall_o stays high.
// ----------------------------------------------------------------------------
module text_console_writer_unit
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [7:0]        char_code_i,
  input  logic [7:0]        attribute_i,
  input  logic [4:0]        line_count_i,
  input  logic [COL_W-1:0]  column_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [ADDR_W-1:0] cell_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [CELL_W-1:0] cell_value_o
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  // controller
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  tcw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .attribute_i  (attribute_i),
    .line_count_i (line_count_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .cell_index_i (cell_index_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_value_o (cell_value_o)
  );

endmodule

// ===== design/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker
  import tcw_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [COL_W-1:0]  cursor_col_o,
  input logic [ROW_W-1:0]  cursor_row_o,
  input logic [CELL_W-1:0] cell_value_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cursor_col_o)
      && $stable(cursor_row_o) && $stable(cell_value_o))
    else $error("stalled result changed");

  // a word under execution holds off the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("word accepted during execution");

  // reported cursor stays on screen, a pending scroll sits at column zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cursor_col_o < COL_W'(COLUMNS) && cursor_row_o <= ROW_W'(ROWS)
      && (cursor_row_o != ROW_W'(ROWS) || cursor_col_o == '0))
    else $error("cursor out of range");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cursor_col_o (cursor_col_o),
  .cursor_row_o (cursor_row_o),
  .cell_value_o (cell_value_o)
);
